// ===== rtl/ufc_pkg.sv =====
// Shared types, constants and byte-select helpers for the UDP frame classifier.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ufc_pkg;

    // Frame length limit and the widths that follow from it
    localparam int MAX_FRAME = 2048;
    localparam int POS_W     = $clog2(MAX_FRAME + 1);
    localparam int CMP_W     = (POS_W > 12) ? POS_W : 12;

    // Field widths of the payload
    localparam int BYTE_W   = 8;
    localparam int HW_W     = 4;
    localparam int PORT_W   = 16;
    localparam int IP_W     = 32;
    localparam int TAG_W    = 64;
    localparam int MINP_W   = 8;
    localparam int CLASS_W  = 2;
    localparam int OFFSET_W = 7;
    localparam int PLEN_W   = 12;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_IP        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_PORT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNICAST_PORT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOVERY_TAG   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_TAG = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PAYLOAD     = 3'd6;

    // Configuration reset values (192.168.4.1, 224.76.78.75, port 20808)
    localparam logic [IP_W-1:0]   OWN_IP_RESET      = 32'hC0A8_0401;
    localparam logic [IP_W-1:0]   GROUP_IP_RESET    = 32'hE04C_4E4B;
    localparam logic [PORT_W-1:0] DEFAULT_PORT      = 16'd20808;
    localparam logic [TAG_W-1:0]  TAG_RESET         = '0;
    localparam logic [MINP_W-1:0] MIN_PAYLOAD_FLOOR = 8'd8;

    // Frame classes
    localparam logic [CLASS_W-1:0] CLASS_PASS        = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_JUNK        = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_DISCOVERY   = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_MEASUREMENT = 2'd3;

    // Header byte values
    localparam logic [BYTE_W-1:0] ETHERTYPE_HI = 8'h08;
    localparam logic [BYTE_W-1:0] ETHERTYPE_LO = 8'h00;
    localparam logic [BYTE_W-1:0] PROTO_UDP    = 8'd17;

    // Byte positions, offsets and lengths within the frame
    localparam logic [CMP_W-1:0] P_ETH_HI     = CMP_W'(12);
    localparam logic [CMP_W-1:0] P_ETH_LO     = CMP_W'(13);
    localparam logic [CMP_W-1:0] P_IHL        = CMP_W'(14);
    localparam logic [CMP_W-1:0] P_PROTO      = CMP_W'(23);
    localparam logic [CMP_W-1:0] P_DIP_FIRST  = CMP_W'(30);
    localparam logic [CMP_W-1:0] P_DIP_LAST   = CMP_W'(33);
    localparam logic [CMP_W-1:0] P_PORT_HI_BK = CMP_W'(6);
    localparam logic [CMP_W-1:0] P_PORT_LO_BK = CMP_W'(5);
    localparam logic [CMP_W-1:0] TAG_BYTES    = CMP_W'(8);
    localparam logic [CMP_W-1:0] MIN_FRAME_LEN = CMP_W'(42);
    localparam logic [OFFSET_W-1:0] OFFSET_BASE = 7'd22;

    typedef struct packed {
        logic [IP_W-1:0]   own_ip;
        logic [IP_W-1:0]   group_ip;
        logic [PORT_W-1:0] group_port;
        logic [PORT_W-1:0] unicast_port;
        logic [TAG_W-1:0]  discovery_tag;
        logic [TAG_W-1:0]  measurement_tag;
        logic [MINP_W-1:0] min_payload;
    } cfg_t;

    typedef struct packed {
        logic [CLASS_W-1:0]  frame_class;
        logic [OFFSET_W-1:0] payload_offset;
        logic [PLEN_W-1:0]   payload_length;
    } result_t;

    // Pick byte k of an address, k = 0 least significant
    function automatic logic [BYTE_W-1:0] ip_byte(input logic [IP_W-1:0] ip,
                                                  input logic [1:0] k);
        ip_byte = ip[BYTE_W*k +: BYTE_W];
    endfunction

    // Pick byte k of a tag, k = 0 least significant
    function automatic logic [BYTE_W-1:0] tag_byte(input logic [TAG_W-1:0] tag,
                                                   input logic [2:0] k);
        tag_byte = tag[BYTE_W*k +: BYTE_W];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/udp_frame_classifier_core.sv =====
// Top level of the UDP frame classifier: config registers, parser, output register.
// Depends on ufc_pkg, ufc_cfg_regs, ufc_parser and ufc_result_reg.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_stall  frame_byte[7:0], last_byte
//   out      out_valid/out_stall  frame_class[1:0], payload_offset[6:0], payload_length[11:0]
//   cfg      cfg_wr_en            cfg_index[2:0], cfg_wdata[63:0]
//
// One byte per cycle is accepted unless stalled; out_valid rises once a result is registered.
// Throughput is set by the single parse stage between the input and output registers.
// Reset clears handshake and per-frame state and loads the register defaults.
// in_stall rises only when a final byte waits for a result slot still held by out_stall.
`default_nettype none

module udp_frame_classifier_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire logic [ufc_pkg::BYTE_W-1:0]    frame_byte,
    input  wire logic                          last_byte,
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      logic [ufc_pkg::CLASS_W-1:0]   frame_class,
    output      logic [ufc_pkg::OFFSET_W-1:0]  payload_offset,
    output      logic [ufc_pkg::PLEN_W-1:0]    payload_length,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ufc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ufc_pkg::TAG_W-1:0]     cfg_wdata
);
    import ufc_pkg::*;

    cfg_t    cfg;
    result_t res;
    logic    res_load;
    logic    out_free;

    ufc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ufc_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .cfg        (cfg),
        .out_free   (out_free),
        .res_load   (res_load),
        .res        (res)
    );

    ufc_result_reg u_result_reg (
        .clk            (clk),
        .rst_n          (rst_n),
        .res_load       (res_load),
        .res            (res),
        .out_free       (out_free),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_class    (frame_class),
        .payload_offset (payload_offset),
        .payload_length (payload_length)
    );

endmodule

`default_nettype wire

// ===== rtl/ufc_cfg_regs.sv =====
// Configuration register file of the UDP frame classifier.
// Depends on ufc_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module ufc_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ufc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ufc_pkg::TAG_W-1:0]     cfg_wdata,
    output      ufc_pkg::cfg_t                 cfg
);
    import ufc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_OWN_IP:          cfg_next.own_ip          = cfg_wdata[IP_W-1:0];
                REG_GROUP_IP:        cfg_next.group_ip        = cfg_wdata[IP_W-1:0];
                REG_GROUP_PORT:      cfg_next.group_port      = cfg_wdata[PORT_W-1:0];
                REG_UNICAST_PORT:    cfg_next.unicast_port    = cfg_wdata[PORT_W-1:0];
                REG_DISCOVERY_TAG:   cfg_next.discovery_tag   = cfg_wdata;
                REG_MEASUREMENT_TAG: cfg_next.measurement_tag = cfg_wdata;
                REG_MIN_PAYLOAD:     cfg_next.min_payload     = cfg_wdata[MINP_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_ip          <= OWN_IP_RESET;
            cfg_reg.group_ip        <= GROUP_IP_RESET;
            cfg_reg.group_port      <= DEFAULT_PORT;
            cfg_reg.unicast_port    <= DEFAULT_PORT;
            cfg_reg.discovery_tag   <= TAG_RESET;
            cfg_reg.measurement_tag <= TAG_RESET;
            cfg_reg.min_payload     <= MIN_PAYLOAD_FLOOR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/ufc_parser.sv =====
// Input register, per-frame header tracking and classification.
// Depends on ufc_pkg; feeds a finished result to ufc_result_reg.
`default_nettype none

module ufc_parser (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output      logic                       in_stall,
    input  wire logic [ufc_pkg::BYTE_W-1:0] frame_byte,
    input  wire logic                       last_byte,
    input  wire ufc_pkg::cfg_t              cfg,
    input  wire logic                       out_free,
    output      logic                       res_load,
    output      ufc_pkg::result_t           res
);
    import ufc_pkg::*;

    // Input register
    logic              s1_valid_reg, s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_last_reg;

    // Per-frame state
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [HW_W-1:0]   hw_reg, hw_next;
    logic              eth_ok_reg, eth_ok_next;
    logic              proto_ok_reg, proto_ok_next;
    logic              dst_group_reg, dst_group_next;
    logic              dst_own_reg, dst_own_next;
    logic [PORT_W-1:0] dport_reg, dport_next;
    logic              disc_reg, disc_next;
    logic              meas_reg, meas_next;

    // Updated values after the current byte
    logic [POS_W-1:0]  pos_upd;
    logic [HW_W-1:0]   hw_upd;
    logic              eth_ok_upd, proto_ok_upd, dst_group_upd, dst_own_upd;
    logic [PORT_W-1:0] dport_upd;
    logic              disc_upd, meas_upd;

    logic                s1_fire, accept, in_range, in_dip, in_tag;
    logic [CMP_W-1:0]    pos_x, off_x, dip_rel, tag_rel;
    logic [OFFSET_W-1:0] off_cur, off_res;
    logic [CMP_W-1:0]    len_x, offr_x, plen_x;
    logic [MINP_W-1:0]   minp;
    logic                len_ok, size_ok, to_group, to_own;
    logic [CLASS_W-1:0]  cls;

    // Handshake: a non-final byte always drains, a final one needs the result slot
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign accept   = in_valid && !in_stall;
    assign res_load = s1_fire && s1_last_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Examine the byte at the current position
    always_comb
    begin
        pos_x    = CMP_W'(pos_reg);
        off_cur  = OFFSET_BASE + {1'b0, hw_reg, 2'b00};
        off_x    = CMP_W'(off_cur);
        in_range = pos_reg < POS_W'(MAX_FRAME);
        dip_rel  = pos_x - P_DIP_FIRST;
        tag_rel  = pos_x - off_x;
        in_dip   = (pos_x >= P_DIP_FIRST) && (pos_x <= P_DIP_LAST);
        in_tag   = (pos_x >= off_x) && (tag_rel < TAG_BYTES);

        pos_upd       = pos_reg;
        hw_upd        = hw_reg;
        eth_ok_upd    = eth_ok_reg;
        proto_ok_upd  = proto_ok_reg;
        dst_group_upd = dst_group_reg;
        dst_own_upd   = dst_own_reg;
        dport_upd     = dport_reg;
        disc_upd      = disc_reg;
        meas_upd      = meas_reg;

        if (in_range)
        begin
            if ((pos_x == P_ETH_HI && s1_byte_reg != ETHERTYPE_HI) ||
                (pos_x == P_ETH_LO && s1_byte_reg != ETHERTYPE_LO))
            begin
                eth_ok_upd = 1'b0;
            end
            if (pos_x == P_IHL)
            begin
                hw_upd = s1_byte_reg[HW_W-1:0];
            end
            if (pos_x == P_PROTO)
            begin
                proto_ok_upd = (s1_byte_reg == PROTO_UDP);
            end
            if (in_dip)
            begin
                if (s1_byte_reg != ip_byte(cfg.group_ip, ~dip_rel[1:0]))
                begin
                    dst_group_upd = 1'b0;
                end
                if (s1_byte_reg != ip_byte(cfg.own_ip, ~dip_rel[1:0]))
                begin
                    dst_own_upd = 1'b0;
                end
            end
            if (pos_x == off_x - P_PORT_HI_BK)
            begin
                dport_upd[PORT_W-1:BYTE_W] = s1_byte_reg;
            end
            if (pos_x == off_x - P_PORT_LO_BK)
            begin
                dport_upd[BYTE_W-1:0] = s1_byte_reg;
            end
            if (in_tag)
            begin
                if (s1_byte_reg != tag_byte(cfg.discovery_tag, ~tag_rel[2:0]))
                begin
                    disc_upd = 1'b0;
                end
                if (s1_byte_reg != tag_byte(cfg.measurement_tag, ~tag_rel[2:0]))
                begin
                    meas_upd = 1'b0;
                end
            end
            pos_upd = pos_reg + POS_W'(1);
        end
    end

    // Classify the frame as it stands after this byte
    always_comb
    begin
        off_res  = OFFSET_BASE + {1'b0, hw_upd, 2'b00};
        offr_x   = CMP_W'(off_res);
        len_x    = CMP_W'(pos_upd);
        plen_x   = (len_x > offr_x) ? (len_x - offr_x) : '0;
        minp     = (cfg.min_payload < MIN_PAYLOAD_FLOOR) ? MIN_PAYLOAD_FLOOR
                                                         : cfg.min_payload;
        len_ok   = len_x >= MIN_FRAME_LEN;
        size_ok  = len_x >= (offr_x + CMP_W'(minp));
        to_group = dst_group_upd && (dport_upd == cfg.group_port);
        to_own   = dst_own_upd && (dport_upd == cfg.unicast_port);

        cls = CLASS_PASS;
        if (len_ok && eth_ok_upd && proto_ok_upd && size_ok && (to_group || to_own))
        begin
            priority if (disc_upd)
            begin
                cls = CLASS_DISCOVERY;
            end
            else if (meas_upd)
            begin
                cls = CLASS_MEASUREMENT;
            end
            else if (to_group)
            begin
                cls = CLASS_JUNK;
            end
            else
            begin
                cls = CLASS_PASS;
            end
        end

        res.frame_class    = cls;
        res.payload_offset = off_res;
        res.payload_length = plen_x[PLEN_W-1:0];
    end

    // Advance the state, or clear it after the final byte
    always_comb
    begin
        pos_next       = pos_reg;
        hw_next        = hw_reg;
        eth_ok_next    = eth_ok_reg;
        proto_ok_next  = proto_ok_reg;
        dst_group_next = dst_group_reg;
        dst_own_next   = dst_own_reg;
        dport_next     = dport_reg;
        disc_next      = disc_reg;
        meas_next      = meas_reg;
        if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                pos_next       = '0;
                hw_next        = '0;
                eth_ok_next    = 1'b1;
                proto_ok_next  = 1'b0;
                dst_group_next = 1'b1;
                dst_own_next   = 1'b1;
                dport_next     = '0;
                disc_next      = 1'b1;
                meas_next      = 1'b1;
            end
            else
            begin
                pos_next       = pos_upd;
                hw_next        = hw_upd;
                eth_ok_next    = eth_ok_upd;
                proto_ok_next  = proto_ok_upd;
                dst_group_next = dst_group_upd;
                dst_own_next   = dst_own_upd;
                dport_next     = dport_upd;
                disc_next      = disc_upd;
                meas_next      = meas_upd;
            end
        end
    end

    // Control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            hw_reg        <= '0;
            eth_ok_reg    <= 1'b1;
            proto_ok_reg  <= 1'b0;
            dst_group_reg <= 1'b1;
            dst_own_reg   <= 1'b1;
            dport_reg     <= '0;
            disc_reg      <= 1'b1;
            meas_reg      <= 1'b1;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            pos_reg       <= pos_next;
            hw_reg        <= hw_next;
            eth_ok_reg    <= eth_ok_next;
            proto_ok_reg  <= proto_ok_next;
            dst_group_reg <= dst_group_next;
            dst_own_reg   <= dst_own_next;
            dport_reg     <= dport_next;
            disc_reg      <= disc_next;
            meas_reg      <= meas_next;
        end
    end

    // Capture the incoming transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= frame_byte;
            s1_last_reg <= last_byte;
        end
    end

`ifndef SYNTHESIS
    a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_FRAME))
        else $error("byte position beyond frame limit");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> (pos_reg == '0 && hw_reg == '0))
        else $error("frame state not cleared after final byte");

    a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> out_free)
        else $error("result loaded into an occupied slot");

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_last_reg && !out_free))
        else $error("input stalled without a blocked final byte");
`endif

endmodule

`default_nettype wire

// ===== rtl/ufc_result_reg.sv =====
// Output register of the UDP frame classifier: holds one result until taken.
// Depends on ufc_pkg for result_t.
`default_nettype none

module ufc_result_reg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         res_load,
    input  wire ufc_pkg::result_t             res,
    output      logic                         out_free,
    output      logic                         out_valid,
    input  wire logic                         out_stall,
    output      logic [ufc_pkg::CLASS_W-1:0]  frame_class,
    output      logic [ufc_pkg::OFFSET_W-1:0] payload_offset,
    output      logic [ufc_pkg::PLEN_W-1:0]   payload_length
);
    import ufc_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t res_reg;

    // Slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_class    = res_reg.frame_class;
    assign payload_offset = res_reg.payload_offset;
    assign payload_length = res_reg.payload_length;

endmodule

`default_nettype wire
